FILE: design/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants, opcodes, status codes and queue entry control type.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int VALUE_W        = 64;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;
  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_REM = 3'd3;
  localparam logic [OP_W-1:0] OP_QUO = 3'd4;
  localparam logic [OP_W-1:0] OP_EQ  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TYPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIV  = 2'd3;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_CONST = 3'd0;
  localparam logic [KIND_W-1:0] K_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] K_SUB   = 3'd2;
  localparam logic [KIND_W-1:0] K_MUL   = 3'd3;
  localparam logic [KIND_W-1:0] K_REM   = 3'd4;
  localparam logic [KIND_W-1:0] K_QUO   = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic                bit_val;
  } csa_ctl_t;

endpackage

FILE: design/csa_front.sv
// ----------------------------------------------------------------------------
// csa_front
// Decodes the opcode and resolves type errors, divide errors and equality.
// ----------------------------------------------------------------------------
module csa_front #(
  parameter int DATA_WIDTH = csa_pkg::DATA_WIDTH_DEF
) (
  input  logic [csa_pkg::OP_W-1:0]    op,
  input  logic [csa_pkg::VALUE_W-1:0] operand_a,
  input  logic [csa_pkg::VALUE_W-1:0] operand_b,
  input  logic                        a_is_integer,
  input  logic                        b_is_integer,
  output csa_pkg::csa_ctl_t           ctl,
  output logic [DATA_WIDTH-1:0]       a,
  output logic [DATA_WIDTH-1:0]       b
);

  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic ints;
  logic div_err;

  assign a       = operand_a[DATA_WIDTH-1:0];
  assign b       = operand_b[DATA_WIDTH-1:0];
  assign ints    = a_is_integer & b_is_integer;
  assign div_err = (b == '0) || ((a == MINV) && (b == '1));

  always_comb begin
    ctl.kind    = csa_pkg::K_CONST;
    ctl.status  = csa_pkg::ST_OK;
    ctl.bit_val = 1'b0;
    case (op)
      csa_pkg::OP_ADD, csa_pkg::OP_SUB, csa_pkg::OP_MUL,
      csa_pkg::OP_REM, csa_pkg::OP_QUO: begin
        if (!ints) begin
          ctl.status = csa_pkg::ST_TYPE;
        end else if (op == csa_pkg::OP_ADD) begin
          ctl.kind = csa_pkg::K_ADD;
        end else if (op == csa_pkg::OP_SUB) begin
          ctl.kind = csa_pkg::K_SUB;
        end else if (op == csa_pkg::OP_MUL) begin
          ctl.kind = csa_pkg::K_MUL;
        end else if (div_err) begin
          ctl.status = csa_pkg::ST_DIV;
        end else if (op == csa_pkg::OP_REM) begin
          ctl.kind = csa_pkg::K_REM;
        end else begin
          ctl.kind = csa_pkg::K_QUO;
        end
      end
      csa_pkg::OP_EQ: begin
        ctl.bit_val = (a == b);
      end
      default: begin
        ctl.bit_val = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/csa_fifo.sv
// ----------------------------------------------------------------------------
// csa_fifo
// Short queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module csa_fifo #(
  parameter int DATA_WIDTH = csa_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csa_pkg::csa_ctl_t     push_ctl,
  input  logic [DATA_WIDTH-1:0] push_a,
  input  logic [DATA_WIDTH-1:0] push_b,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output csa_pkg::csa_ctl_t     q_ctl,
  output logic [DATA_WIDTH-1:0] q_a,
  output logic [DATA_WIDTH-1:0] q_b
);

  localparam int DEPTH = csa_pkg::FIFO_DEPTH_DEF;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  csa_pkg::csa_ctl_t     ctl_mem [DEPTH];
  logic [DATA_WIDTH-1:0] a_mem   [DEPTH];
  logic [DATA_WIDTH-1:0] b_mem   [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign q_ctl = ctl_mem[rd_ptr_r];
  assign q_a   = a_mem[rd_ptr_r];
  assign q_b   = b_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= push_ctl;
      a_mem[wr_ptr_r]   <= push_a;
      b_mem[wr_ptr_r]   <= push_b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");

endmodule

FILE: design/csa_back.sv
// ----------------------------------------------------------------------------
// csa_back
// Execute unit: registered add/sub, shared 32-bit multiplier over four
// partial products, and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module csa_back #(
  parameter int DATA_WIDTH = csa_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  csa_pkg::csa_ctl_t                q_ctl,
  input  logic [DATA_WIDTH-1:0]            q_a,
  input  logic [DATA_WIDTH-1:0]            q_b,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csa_pkg::VALUE_W-1:0]      out_value,
  output logic [csa_pkg::STATUS_W-1:0]     out_status
);

  localparam int W    = DATA_WIDTH;
  localparam int HALF = (W + 1) / 2;
  localparam int ACCW = 4 * HALF;
  localparam int CW   = $clog2(W + 1);
  localparam int OW   = csa_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OW-1:0]               out_value_r, out_value_nxt;
  logic [csa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [W-1:0]      ma_r, ma_nxt, mb_r, mb_nxt, rem_r, rem_nxt;
  logic              neg_r, neg_nxt, is_mul_r, is_mul_nxt, is_rem_r, is_rem_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2*HALF-1:0] prod_r, prod_nxt;
  logic [1:0]        sh_r, sh_nxt;
  logic [ACCW-1:0]   acc_r, acc_nxt;

  logic [W-1:0]      sum, dif, abs_a, abs_b, trial, fin_mag, lim;
  logic [2*HALF-1:0] ma_x, mb_x;
  logic [HALF-1:0]   pa, pb;
  logic [ACCW-1:0]   prod_sh;
  logic              sa, sb, add_ovf, sub_ovf, ge, mul_ovf;
  logic signed [W-1:0] res_s;

  assign sa      = q_a[W-1];
  assign sb      = q_b[W-1];
  assign sum     = q_a + q_b;
  assign dif     = q_a - q_b;
  assign add_ovf = (sa == sb) && (sum[W-1] != sa);
  assign sub_ovf = (sa != sb) && (dif[W-1] != sa);
  assign abs_a   = sa ? (~q_a + 1'b1) : q_a;
  assign abs_b   = sb ? (~q_b + 1'b1) : q_b;

  assign q_pop = (state_r == S_IDLE) && q_valid && (!out_valid_r || out_ready);

  assign ma_x = (2*HALF)'(ma_r);
  assign mb_x = (2*HALF)'(mb_r);
  assign pa   = step_r[1] ? ma_x[2*HALF-1:HALF] : ma_x[HALF-1:0];
  assign pb   = step_r[0] ? mb_x[2*HALF-1:HALF] : mb_x[HALF-1:0];

  always_comb begin
    case (sh_r)
      2'd0:    prod_sh = ACCW'(prod_r);
      2'd1:    prod_sh = ACCW'(prod_r) << HALF;
      default: prod_sh = ACCW'(prod_r) << (2 * HALF);
    endcase
  end

  assign trial   = {rem_r[W-2:0], ma_r[W-1]};
  assign ge      = (trial >= mb_r);
  assign lim     = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign fin_mag = is_mul_r ? acc_r[W-1:0] : (is_rem_r ? rem_r : ma_r);
  assign mul_ovf = is_mul_r && ((|acc_r[ACCW-1:W]) || (acc_r[W-1:0] > lim));
  assign res_s   = mul_ovf ? '0 : (neg_r ? (~fin_mag + 1'b1) : fin_mag);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    is_mul_nxt     = is_mul_r;
    is_rem_nxt     = is_rem_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    sh_nxt         = sh_r;
    acc_nxt        = acc_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          ma_nxt     = abs_a;
          mb_nxt     = abs_b;
          rem_nxt    = '0;
          acc_nxt    = '0;
          step_nxt   = '0;
          cnt_nxt    = CW'(W);
          is_mul_nxt = (q_ctl.kind == csa_pkg::K_MUL);
          is_rem_nxt = (q_ctl.kind == csa_pkg::K_REM);
          neg_nxt    = (q_ctl.kind == csa_pkg::K_REM) ? sa : (sa ^ sb);
          case (q_ctl.kind)
            csa_pkg::K_ADD: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = add_ovf ? '0 : OW'($signed(sum));
              out_status_nxt = add_ovf ? csa_pkg::ST_OVF : csa_pkg::ST_OK;
            end
            csa_pkg::K_SUB: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = sub_ovf ? '0 : OW'($signed(dif));
              out_status_nxt = sub_ovf ? csa_pkg::ST_OVF : csa_pkg::ST_OK;
            end
            csa_pkg::K_MUL: begin
              state_nxt = S_MUL;
            end
            csa_pkg::K_REM, csa_pkg::K_QUO: begin
              state_nxt = S_DIV;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = OW'(q_ctl.bit_val);
              out_status_nxt = q_ctl.status;
            end
          endcase
        end
      end
      S_MUL: begin
        if (step_r != 3'd0) begin
          acc_nxt = acc_r + prod_sh;
        end
        prod_nxt = pa * pb;
        sh_nxt   = 2'(step_r[1]) + 2'(step_r[0]);
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd4) begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? (trial - mb_r) : trial;
        ma_nxt  = {ma_r[W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_FIN;
        end
      end
      default: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = OW'(res_s);
        out_status_nxt = mul_ovf ? csa_pkg::ST_OVF : csa_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    ma_r         <= ma_nxt;
    mb_r         <= mb_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    is_mul_r     <= is_mul_nxt;
    is_rem_r     <= is_rem_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    prod_r       <= prod_nxt;
    sh_r         <= sh_nxt;
    acc_r        <= acc_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("result held while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != csa_pkg::ST_OK) |-> out_value_r == '0)
    else $error("nonzero value on error");
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("finish did not load result");

endmodule

FILE: design/checked_signed_alu.sv
// ----------------------------------------------------------------------------
// checked_signed_alu
// Overflow-checked signed ALU: decode front, short queue, execute back.
//
//  channel | ports                                                   | dir
//  in      | in_valid/in_ready, in_op, in_operand_a/b, in_*_is_integer | in
//  out     | out_valid/out_ready, out_value, out_status               | out
//
// Add, subtract, equality and every error case: one transfer per cycle while the back is idle and out_ready is high.
// Multiply: runs through the back unit's S_MUL and S_FIN states (shared 32-bit multiplier, 4 products).
// Quotient and remainder: restoring division in the back unit, one quotient bit per cycle.
// A 2-entry queue lets the input take up to two transfers while the back is busy.
// Reset is synchronous, active low, and empties queue and result register.
// ----------------------------------------------------------------------------
module checked_signed_alu #(
  parameter int DATA_WIDTH = csa_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [csa_pkg::OP_W-1:0]     in_op,
  input  logic [csa_pkg::VALUE_W-1:0]  in_operand_a,
  input  logic [csa_pkg::VALUE_W-1:0]  in_operand_b,
  input  logic                         in_a_is_integer,
  input  logic                         in_b_is_integer,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csa_pkg::VALUE_W-1:0]  out_value,
  output logic [csa_pkg::STATUS_W-1:0] out_status
);

  csa_pkg::csa_ctl_t     f_ctl, q_ctl;
  logic [DATA_WIDTH-1:0] f_a, f_b, q_a, q_b;
  logic                  full, q_valid, q_pop, push;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  csa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .op           (in_op),
    .operand_a    (in_operand_a),
    .operand_b    (in_operand_b),
    .a_is_integer (in_a_is_integer),
    .b_is_integer (in_b_is_integer),
    .ctl          (f_ctl),
    .a            (f_a),
    .b            (f_b)
  );

  csa_fifo #(.DATA_WIDTH(DATA_WIDTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ctl (f_ctl),
    .push_a   (f_a),
    .push_b   (f_b),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .q_ctl    (q_ctl),
    .q_a      (q_a),
    .q_b      (q_b)
  );

  csa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_a        (q_a),
    .q_b        (q_b),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
